@@ rtl/fpcr_pkg.sv @@
package fpcr_pkg;

    // Fixed-point format of the bracket points.
    localparam int FRAC_BITS = 24;

    // Quotient bits of the chord fraction below the binary point.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Field widths.
    localparam int POINT_W = 32;
    localparam int VALUE_W = 64;
    localparam int COEF_W  = 16;
    localparam int TOL_W   = 31;
    localparam int STEP_W  = 10;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 3;

    // Result status codes.
    localparam logic [1:0] ST_CONVERGED   = 2'd0;
    localparam logic [1:0] ST_NO_BRACKET  = 2'd1;
    localparam logic [1:0] ST_LIMIT       = 2'd2;
    localparam logic [1:0] ST_ZERO_DENOM  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONSTANT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 3'd4;

endpackage

@@ rtl/fpcr_div.sv @@
module fpcr_div
    import fpcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] num,
    input  logic [VALUE_W-1:0] den,
    output logic               done,
    output logic [DIV_STEPS:0] quot
);

    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [DIV_STEPS:0]   quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [VALUE_W:0]     rem_shift;
    logic [VALUE_W:0]     rem_diff;
    logic                 bit_set;

    // One restoring step per cycle: shift the remainder and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, den};
        bit_set   = (rem_shift >= {1'b0, den});
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (num >= den)
            begin
                rem_next  = num - den;
                quot_next = (DIV_STEPS+1)'(1);
            end
            else
            begin
                rem_next  = num;
                quot_next = '0;
            end
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (bit_set)
            begin
                rem_next = rem_diff[VALUE_W-1:0];
            end
            else
            begin
                rem_next = rem_shift[VALUE_W-1:0];
            end
            quot_next = {quot_reg[DIV_STEPS-1:0], bit_set};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/false_position_cubic_root_core.sv @@
// Sequence: the cubic is evaluated at both bracket ends, and a bracket without a sign change
// goes straight to the result. Otherwise each chord step is a check, the divider (one quotient
// bit per cycle), the offset multiply and the cubic evaluation on the one shared 32x32
// multiplier; then the result is handed over. One transaction at a time: a new bracket is
// taken only when idle, and the hand-over waits while an earlier result is still pending.
// Reset (asynchronous, active low) restores the default coefficients,
// tolerance and iteration limit, and leaves the block idle with no result pending.
module false_position_cubic_root_core
    import fpcr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POINT_W-1:0] left_end,
    input  logic signed [POINT_W-1:0] right_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [POINT_W-1:0] root_estimate,
    output logic [1:0]                status,
    output logic [STEP_W-1:0]         steps_taken
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_XCALC = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        EV_LEFT  = 2'd0,
        EV_RIGHT = 2'd1,
        EV_CHORD = 2'd2
    } eval_ctx_t;

    state_t    state_reg, state_next;
    eval_ctx_t ctx_reg, ctx_next;

    logic signed [COEF_W-1:0] c2_reg, c1_reg, c0_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic [STEP_W-1:0]        limit_reg;

    logic [2:0]                ev_cnt_reg;
    logic signed [POINT_W-1:0] lp_reg, rp_reg, x_reg, ex_reg;
    logic signed [VALUE_W-1:0] lv_reg, rv_reg, acc_reg;
    logic [VALUE_W-1:0]        sqm_reg, part_reg, prod_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic                      first_reg;
    logic [DIV_STEPS:0]        q_reg;
    logic signed [POINT_W-1:0] res_root_reg;
    logic [1:0]                res_status_reg;
    logic [STEP_W-1:0]         res_steps_reg;
    logic                      out_valid_reg;
    logic signed [POINT_W-1:0] out_root_reg;
    logic [1:0]                out_status_reg;
    logic [STEP_W-1:0]         out_steps_reg;

    logic [POINT_W-1:0]        abs_x;
    logic [POINT_W-1:0]        abs_c1, abs_c2;
    logic [POINT_W-1:0]        mul_a, mul_b;
    logic [VALUE_W-1:0]        t1m;
    logic signed [VALUE_W-1:0] t1s, t0s, cube_s, t2_s, f_new;
    logic [VALUE_W+31:0]       cube_wide;
    logic [VALUE_W-1:0]        cube_m, t2_m;
    logic [VALUE_W-1:0]        abs_lv, abs_rv, abs_f, den;
    logic                      bracket_ok, same_sign, converged, at_limit;
    logic [STEP_W-1:0]         limit_eff;
    logic signed [POINT_W:0]   diff;
    logic [POINT_W:0]          diff_m;
    logic [POINT_W-1:0]        delta;
    logic signed [POINT_W-1:0] x_new;
    logic                      div_start, div_done;
    logic [DIV_STEPS:0]        div_quot;

    // Chord fraction divider.
    fpcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (abs_lv),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Magnitudes and signed terms of the cubic evaluation.
    always_comb
    begin
        abs_x  = ex_reg[POINT_W-1] ? POINT_W'(-ex_reg) : POINT_W'(ex_reg);
        abs_c1 = c1_reg[COEF_W-1] ? POINT_W'(-32'(c1_reg)) : POINT_W'(c1_reg);
        abs_c2 = c2_reg[COEF_W-1] ? POINT_W'(-32'(c2_reg)) : POINT_W'(c2_reg);
        t1m    = prod_reg;
        t1s    = (c1_reg[COEF_W-1] ^ ex_reg[POINT_W-1]) ? -$signed(t1m) : $signed(t1m);
        t0s    = VALUE_W'(c0_reg) <<< FRAC_BITS;
        cube_wide = {prod_reg, 32'd0} + {32'd0, part_reg};
        cube_m = VALUE_W'(cube_wide >> FRAC_BITS);
        cube_s = ex_reg[POINT_W-1] ? -$signed(cube_m) : $signed(cube_m);
        t2_m   = VALUE_W'(cube_wide);
        t2_s   = c2_reg[COEF_W-1] ? -$signed(t2_m) : $signed(t2_m);
        f_new  = acc_reg + t2_s;
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = abs_x;
        mul_b = abs_x;
        if (state_reg == S_MUL)
        begin
            mul_a = diff_m[POINT_W-1:0];
            mul_b = q_reg[DIV_STEPS-1:0];
        end
        else
        begin
            unique case (ev_cnt_reg)
                3'd1:    mul_b = abs_c1;
                3'd2:    mul_a = sqm_reg[31:0];
                3'd3:    mul_a = sqm_reg[63:32];
                3'd4:
                begin
                    mul_a = sqm_reg[31:0];
                    mul_b = abs_c2;
                end
                3'd5:
                begin
                    mul_a = sqm_reg[63:32];
                    mul_b = abs_c2;
                end
                default: mul_b = abs_x;
            endcase
        end
    end

    // Bracket, chord and stop tests.
    always_comb
    begin
        abs_lv     = lv_reg[VALUE_W-1] ? VALUE_W'(-lv_reg) : VALUE_W'(lv_reg);
        abs_rv     = rv_reg[VALUE_W-1] ? VALUE_W'(-rv_reg) : VALUE_W'(rv_reg);
        den        = abs_lv + abs_rv;
        bracket_ok = (lv_reg < 0 && rv_reg > 0) || (lv_reg > 0 && rv_reg < 0);
        abs_f      = f_new[VALUE_W-1] ? VALUE_W'(-f_new) : VALUE_W'(f_new);
        same_sign  = (f_new > 0 && lv_reg > 0) || (f_new < 0 && lv_reg < 0);
        converged  = (abs_f < VALUE_W'(tol_reg));
        limit_eff  = (limit_reg == '0) ? STEP_W'(1) : limit_reg;
        at_limit   = (cnt_reg >= limit_eff);
        diff       = (POINT_W+1)'(rp_reg) - (POINT_W+1)'(lp_reg);
        diff_m     = diff[POINT_W] ? (POINT_W+1)'(-diff) : (POINT_W+1)'(diff);
        delta      = q_reg[DIV_STEPS] ? diff_m[POINT_W-1:0] : prod_reg[63:32];
        x_new      = diff[POINT_W] ? (lp_reg - $signed(delta)) : (lp_reg + $signed(delta));
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                    ctx_next   = EV_LEFT;
                end
            end
            S_EVAL:
            begin
                if (ev_cnt_reg == 3'd6)
                begin
                    unique case (ctx_reg)
                        EV_LEFT:  ctx_next = EV_RIGHT;
                        EV_RIGHT: state_next = S_CHECK;
                        default:
                        begin
                            if (converged || at_limit)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_CHECK;
                            end
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if ((first_reg && !bracket_ok) || den == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_XCALC;
            S_XCALC:
            begin
                state_next = S_EVAL;
                ctx_next   = EV_CHORD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctx_reg       <= EV_LEFT;
            ev_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            c2_reg        <= COEF_W'(2);
            c1_reg        <= COEF_W'(10);
            c0_reg        <= -COEF_W'(20);
            tol_reg       <= TOL_W'(17);
            limit_reg     <= STEP_W'(100);
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            if (state_reg == S_EVAL && ev_cnt_reg != 3'd6)
            begin
                ev_cnt_reg <= ev_cnt_reg + 1'b1;
            end
            else
            begin
                ev_cnt_reg <= '0;
            end
            if (state_reg == S_OUT && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_COEF_SQUARE:   c2_reg    <= cfg_data[COEF_W-1:0];
                    CFG_COEF_LINEAR:   c1_reg    <= cfg_data[COEF_W-1:0];
                    CFG_COEF_CONSTANT: c0_reg    <= cfg_data[COEF_W-1:0];
                    CFG_TOLERANCE:     tol_reg   <= cfg_data[TOL_W-1:0];
                    CFG_ITER_LIMIT:    limit_reg <= cfg_data[STEP_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= VALUE_W'(mul_a) * VALUE_W'(mul_b);

        // Cubic evaluation steps.
        if (state_reg == S_EVAL)
        begin
            unique case (ev_cnt_reg)
                3'd1:    sqm_reg <= prod_reg >> FRAC_BITS;
                3'd2:    acc_reg <= t1s + t0s;
                3'd3:    part_reg <= prod_reg;
                3'd4:    acc_reg <= acc_reg + cube_s;
                3'd5:    part_reg <= prod_reg;
                default: ;
            endcase
        end

        // New transaction: load the bracket.
        if (state_reg == S_IDLE && in_valid)
        begin
            lp_reg    <= left_end;
            rp_reg    <= right_end;
            ex_reg    <= left_end;
            x_reg     <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end

        // Evaluation results.
        if (state_reg == S_EVAL && ev_cnt_reg == 3'd6)
        begin
            unique case (ctx_reg)
                EV_LEFT:
                begin
                    lv_reg <= f_new;
                    ex_reg <= rp_reg;
                end
                EV_RIGHT: rv_reg <= f_new;
                default:
                begin
                    if (same_sign)
                    begin
                        lp_reg <= x_reg;
                        lv_reg <= f_new;
                    end
                    else
                    begin
                        rp_reg <= x_reg;
                        rv_reg <= f_new;
                    end
                    res_root_reg   <= x_reg;
                    res_steps_reg  <= cnt_reg;
                    res_status_reg <= converged ? ST_CONVERGED : ST_LIMIT;
                end
            endcase
        end

        // Early exits.
        if (state_reg == S_CHECK)
        begin
            first_reg <= 1'b0;
            if (first_reg && !bracket_ok)
            begin
                res_root_reg   <= '0;
                res_steps_reg  <= '0;
                res_status_reg <= ST_NO_BRACKET;
            end
            else
            begin
                res_root_reg   <= x_reg;
                res_steps_reg  <= cnt_reg;
                res_status_reg <= ST_ZERO_DENOM;
            end
        end

        if (state_reg == S_DIV && div_done)
        begin
            q_reg <= div_quot;
        end

        // New chord crossing point.
        if (state_reg == S_XCALC)
        begin
            x_reg   <= x_new;
            ex_reg  <= x_new;
            cnt_reg <= cnt_reg + 1'b1;
        end

        if (state_reg == S_OUT && state_next == S_IDLE)
        begin
            out_root_reg   <= res_root_reg;
            out_status_reg <= res_status_reg;
            out_steps_reg  <= res_steps_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign root_estimate = out_root_reg;
    assign status        = out_status_reg;
    assign steps_taken   = out_steps_reg;

endmodule

@@ verif/tb_false_position_cubic_root_core.sv @@
`timescale 1ns / 1ps

module tb_false_position_cubic_root_core;
    import fpcr_pkg::*;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic signed [POINT_W-1:0] root;
        logic [1:0]                code;
        logic [STEP_W-1:0]         steps;
    } root_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [POINT_W-1:0] left_end = '0;
    logic signed [POINT_W-1:0] right_end = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [POINT_W-1:0] root_estimate;
    logic [1:0]                status;
    logic [STEP_W-1:0]         steps_taken;

    // Shadow copy of the configuration registers.
    logic signed [COEF_W-1:0] c_square;
    logic signed [COEF_W-1:0] c_linear;
    logic signed [COEF_W-1:0] c_const;
    logic [TOL_W-1:0]         tol_reg;
    logic [STEP_W-1:0]        limit_reg;

    root_result_t expected_roots[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int unsigned cycle_count = 0;

    false_position_cubic_root_core dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor of the root finder.
    // ---------------------------------------------------------------
    function automatic logic [63:0] abs_val(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint signed_sat(bit neg, logic [127:0] m);
        logic [127:0] capped;
        capped = (m > 128'(SAT_MAX)) ? 128'(SAT_MAX) : m;
        return neg ? -longint'(capped[63:0]) : longint'(capped[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh);
        logic [127:0] prod;
        prod = ({64'd0, abs_val(a)} * {64'd0, abs_val(b)}) >> sh;
        return signed_sat((a < 0) != (b < 0), prod);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > SAT_MAX - b)
            return SAT_MAX;
        if (b < 0 && a < -SAT_MAX - b)
            return -SAT_MAX;
        return a + b;
    endfunction

    function automatic longint cubic_value(longint x);
        longint sq;
        longint cu;
        sq = fx_mul(x, x, FRAC_BITS);
        cu = fx_mul(sq, x, FRAC_BITS);
        return add_sat(add_sat(add_sat(cu, fx_mul(sq, longint'(c_square), 0)),
                               longint'(c_linear) * x),
                       longint'(c_const) * longint'(ONE));
    endfunction

    function automatic root_result_t predict_root(logic signed [31:0] l_in,
                                                  logic signed [31:0] r_in);
        root_result_t res;
        longint lp;
        longint rp;
        longint lv;
        longint fr;
        longint x;
        longint y;
        longint diff;
        logic [63:0] am;
        logic [63:0] den;
        logic [63:0] frac;
        logic [63:0] delta;
        logic [127:0] wide_q;
        int count;
        int lim;
        logic [1:0] code;
        lp = longint'(l_in);
        rp = longint'(r_in);
        lv = cubic_value(lp);
        fr = cubic_value(rp);
        x = 0;
        count = 0;
        res = '0;
        if (!((lv < 0 && fr > 0) || (lv > 0 && fr < 0)))
        begin
            res.code = ST_NO_BRACKET;
            return res;
        end
        lim = (limit_reg == 0) ? 1 : int'(limit_reg);
        forever
        begin
            am = abs_val(lv);
            den = am + abs_val(cubic_value(rp));
            if (den == 0)
            begin
                code = ST_ZERO_DENOM;
                break;
            end
            wide_q = {am, 32'd0} / {64'd0, den};
            frac = wide_q[63:0];
            diff = rp - lp;
            delta = (abs_val(diff) * frac) >> 32;
            x = (diff < 0) ? lp - longint'(delta) : lp + longint'(delta);
            count++;
            y = cubic_value(x);
            if ((y > 0 && lv > 0) || (y < 0 && lv < 0))
            begin
                lp = x;
                lv = y;
            end
            else
            begin
                rp = x;
            end
            if (abs_val(y) < {33'd0, tol_reg})
            begin
                code = ST_CONVERGED;
                break;
            end
            if (count >= lim)
            begin
                code = ST_LIMIT;
                break;
            end
        end
        res.root = x[31:0];
        res.code = code;
        res.steps = count[STEP_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Shared driving tasks.
    // ---------------------------------------------------------------
    // One write; the write strobe is then dropped and the write port left idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_COEF_SQUARE:   c_square = val[COEF_W-1:0];
            CFG_COEF_LINEAR:   c_linear = val[COEF_W-1:0];
            CFG_COEF_CONSTANT: c_const = val[COEF_W-1:0];
            CFG_TOLERANCE:     tol_reg = val[TOL_W-1:0];
            CFG_ITER_LIMIT:    limit_reg = val[STEP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_cubic(int sq, int lin, int cst);
        write_reg(CFG_COEF_SQUARE, CFG_W'(sq & 16'hFFFF));
        write_reg(CFG_COEF_LINEAR, CFG_W'(lin & 16'hFFFF));
        write_reg(CFG_COEF_CONSTANT, CFG_W'(cst & 16'hFFFF));
    endtask

    task automatic set_stop(logic [TOL_W-1:0] tol, logic [STEP_W-1:0] lim);
        write_reg(CFG_TOLERANCE, CFG_W'(tol));
        write_reg(CFG_ITER_LIMIT, CFG_W'(lim));
    endtask

    // Sends one bracket; bursts of random length are broken by random gaps.
    task automatic send_bracket(logic signed [31:0] l, logic signed [31:0] r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        left_end <= l;
        right_end <= r;
        do
            @(posedge clk);
        while (!in_ready);
        expected_roots.push_back(predict_root(l, r));
    endtask

    // Lets all pending transactions drain so that registers may change.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result checking, receiver stalls and the watchdog.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        root_result_t want;
        root_result_t got;
        cycle_count++;
        // Receiver stall pattern steps through four modes: always ready, then ready with probability 1/2, 1/4 and 1/8.
        case ((cycle_count >> 8) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase

        if (rst_n && out_valid && out_ready)
        begin
            got.root = root_estimate;
            got.code = status;
            got.steps = steps_taken;
            if (expected_roots.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected transaction: root=%0d status=%0d steps=%0d",
                             got.root, got.code, got.steps);
            end
            else
            begin
                want = expected_roots.pop_front();
                if (want.root !== got.root || want.code !== got.code ||
                    want.steps !== got.steps)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected root=%0d status=%0d steps=%0d, ",
                                  "got root=%0d status=%0d steps=%0d"},
                                 want.root, want.code, want.steps,
                                 got.root, got.code, got.steps);
                end
            end
        end

        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------
    task automatic test_default_cubic;
        send_bracket(0, 2 * ONE);
        // Reversed bracket is taken as given.
        send_bracket(2 * ONE, 0);
        send_bracket(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_bracket(32'sh7FFF_FFFF, 0);
        // Both ends below the root: no sign change.
        send_bracket(0, ONE / 2);
        send_bracket(32'sh8000_0000, 32'sh8000_0000);
        drain();
    endtask

    task automatic test_stop_rules;
        // Zero tolerance with a zero limit still takes one step.
        set_stop(0, 0);
        send_bracket(0, 2 * ONE);
        drain();
        set_stop(0, 1);
        send_bracket(-ONE, 3 * ONE);
        drain();
        set_stop(0, 1023);
        send_bracket(0, 2 * ONE);
        drain();
        set_stop(31'h7FFF_FFFF, 50);
        send_bracket(0, 2 * ONE);
        send_bracket(32'sh8000_0000, 32'sh7FFF_FFFF);
        drain();
    endtask

    task automatic test_extreme_coefficients;
        set_stop(17, 100);
        set_cubic(-32768, 32767, -32768);
        send_bracket(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_bracket(0, 32'sh7FFF_FFFF);
        send_bracket(32'sh8000_0000, 0);
        drain();
        set_cubic(32767, -32768, 32767);
        send_bracket(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_bracket(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_bracket(-ONE, ONE);
        drain();
        // A root exactly at an end point leaves no strict sign change.
        set_cubic(0, 0, 0);
        send_bracket(0, ONE);
        send_bracket(-ONE, ONE / 3);
        drain();
    endtask

    task automatic test_random_phases;
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic [TOL_W-1:0] tol;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_cubic(2, 10, -20);
            else
                set_cubic($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = TOL_W'($urandom_range(1, 1000));
                2: tol = TOL_W'($urandom);
                default: tol = TOL_W'($urandom_range(1000, 1 << 20));
            endcase
            set_stop(tol, STEP_W'($urandom_range(0, 40)));
            for (int n = 0; n < 45; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // Negative left end and positive right end bracket most cubics.
                    l = $signed({1'b1, 31'($urandom)}) >>> $urandom_range(0, 24);
                    r = $signed({1'b0, 31'($urandom)}) >>> $urandom_range(0, 24);
                    if ($urandom_range(0, 4) == 0)
                        {l, r} = {r, l};
                end
                else
                begin
                    l = $urandom;
                    r = $urandom;
                end
                send_bracket(l, r);
            end
            drain();
        end
    endtask

    initial
    begin
        c_square = 16'sd2;
        c_linear = 16'sd10;
        c_const = -16'sd20;
        tol_reg = 31'd17;
        limit_reg = 10'd100;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_cubic();
        test_stop_rules();
        test_extreme_coefficients();
        test_random_phases();

        drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fpcr_pkg.sv
rtl/fpcr_div.sv
rtl/false_position_cubic_root_core.sv
verif/tb_false_position_cubic_root_core.sv
